/* hw/rtl/lfuar_pkg.sv */
// Shared constants and the result record of the LFU aging replacement list.
package lfuar_pkg;

  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 8;
  localparam int EVPAGE_W   = 16;
  localparam int PERIOD_W   = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_AGING_PERIOD   = 2'd0;
  localparam logic [PERIOD_W-1:0]   AGING_PERIOD_RESET = 8'd20;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
    logic                ev_valid;
    logic [EVPAGE_W-1:0] ev_page;
  } result_t;

endpackage

/* hw/rtl/lfuar_engine.sv */
// Entry store and slot sequencer: one scan pass and one reordering sweep per nonzero page request.
module lfuar_engine #(
  parameter int SLOTS      = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [PAGE_BITS-1:0]          page,
  input  logic [lfuar_pkg::PERIOD_W-1:0] period,
  output logic                          busy,
  output logic                          done,
  output lfuar_pkg::result_t            result
);
  import lfuar_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_ZERO  = 3'd5;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  function automatic logic [COUNT_BITS-1:0] age_count(logic [COUNT_BITS-1:0] c, logic en);
    age_count = (en && (c != '0)) ? c - 1'b1 : c;
  endfunction

  // Entry memory: one write and one registered read per cycle.
  entry_t           mem_r [SLOTS];
  logic [SLOTS-1:0] vld_r;
  entry_t           rd_r;
  logic             we;
  logic [IW-1:0]    wa;
  logic [IW-1:0]    ra;
  entry_t           wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_r <= vld_r[ra] ? mem_r[ra] : '0;
  end

  // Slots never written read as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  logic [2:0]            state_r, state_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [PERIOD_W-1:0]   tally_r, tally_nxt;
  logic                  age_r, age_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         h_r, h_nxt;
  logic [COUNT_BITS-1:0] hcnt_r, hcnt_nxt;
  logic                  emp_r, emp_nxt;
  logic [IW-1:0]         u_r, u_nxt;
  logic [PAGE_BITS-1:0]  lastp_r, lastp_nxt;
  logic [IW-1:0]         e_r, e_nxt;
  logic                  evict_r, evict_nxt;
  logic [COUNT_BITS-1:0] cf_r, cf_nxt;
  logic                  placed_r, placed_nxt;
  entry_t                pend_r, pend_nxt;
  logic [IW-1:0]         pos_r, pos_nxt;

  logic [PERIOD_W-1:0]   tally_inc;
  logic                  age_now;
  logic [COUNT_BITS-1:0] cs;
  entry_t                ad;
  entry_t                mentry;
  logic                  shift;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    page_nxt   = page_r;
    tally_nxt  = tally_r;
    age_nxt    = age_r;
    found_nxt  = found_r;
    h_nxt      = h_r;
    hcnt_nxt   = hcnt_r;
    emp_nxt    = emp_r;
    u_nxt      = u_r;
    lastp_nxt  = lastp_r;
    e_nxt      = e_r;
    evict_nxt  = evict_r;
    cf_nxt     = cf_r;
    placed_nxt = placed_r;
    pend_nxt   = pend_r;
    pos_nxt    = pos_r;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    ra         = cnt_r;

    tally_inc = tally_r + 1'b1;
    age_now   = (tally_inc >= period);
    cs        = (hcnt_r == '1) ? hcnt_r : hcnt_r + 1'b1;

    ad.page = rd_r.page;
    ad.cnt  = age_count(rd_r.cnt, age_r);
    mentry.page = page_r;
    mentry.cnt  = cf_r;
    // A hit entry moves ahead of lower counts; a new entry falls behind higher counts.
    shift = found_r ? (ad.cnt < cf_r) : (ad.cnt <= cf_r);

    unique case (state_r)
      ST_IDLE: begin
        ra = '0;
        if (start) begin
          page_nxt   = page;
          found_nxt  = 1'b0;
          emp_nxt    = 1'b0;
          placed_nxt = 1'b0;
          cnt_nxt    = '0;
          if (page == '0) begin
            state_nxt = ST_ZERO;
          end else begin
            age_nxt   = age_now;
            tally_nxt = age_now ? '0 : tally_inc;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ra = cnt_r + 1'b1;
        if (!found_r && (rd_r.page == page_r)) begin
          found_nxt = 1'b1;
          h_nxt     = cnt_r;
          hcnt_nxt  = rd_r.cnt;
        end
        if (!emp_r && (rd_r.page == '0)) begin
          emp_nxt = 1'b1;
          u_nxt   = cnt_r;
        end
        if (cnt_r == LAST) begin
          lastp_nxt = rd_r.page;
          state_nxt = ST_PREP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_PREP: begin
        ra      = LAST;
        cnt_nxt = LAST;
        if (found_r) begin
          e_nxt     = h_r;
          evict_nxt = 1'b0;
          cf_nxt    = age_count(cs, age_r);
        end else begin
          e_nxt     = emp_r ? u_r : LAST;
          evict_nxt = !emp_r;
          cf_nxt    = age_r ? '0 : COUNT_BITS'(1);
        end
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        // Walk from the tail toward the head; the moved entry leaves a hole
        // at its old slot that travels up until the entry drops in.
        ra = cnt_r - 1'b1;
        if (cnt_r > e_r) begin
          we = 1'b1;
          wa = cnt_r;
          wd = ad;
        end else if (cnt_r < e_r) begin
          we = 1'b1;
          wa = cnt_r + 1'b1;
          if (placed_r) begin
            wd       = pend_r;
            pend_nxt = ad;
          end else if (shift) begin
            wd = ad;
          end else begin
            wd         = mentry;
            placed_nxt = 1'b1;
            pos_nxt    = cnt_r + 1'b1;
            pend_nxt   = ad;
          end
        end
        if (cnt_r == '0) begin
          state_nxt = ST_FLUSH;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FLUSH: begin
        we = 1'b1;
        wa = '0;
        wd = placed_r ? pend_r : mentry;
        if (!placed_r) begin
          pos_nxt = '0;
        end
        state_nxt = ST_IDLE;
      end
      ST_ZERO: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tally_r  <= '0;
      age_r    <= 1'b0;
      found_r  <= 1'b0;
      emp_r    <= 1'b0;
      evict_r  <= 1'b0;
      placed_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      tally_r  <= tally_nxt;
      age_r    <= age_nxt;
      found_r  <= found_nxt;
      emp_r    <= emp_nxt;
      evict_r  <= evict_nxt;
      placed_r <= placed_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    h_r     <= h_nxt;
    hcnt_r  <= hcnt_nxt;
    u_r     <= u_nxt;
    lastp_r <= lastp_nxt;
    e_r     <= e_nxt;
    cf_r    <= cf_nxt;
    pend_r  <= pend_nxt;
    pos_r   <= pos_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_FLUSH) || (state_r == ST_ZERO);

  always_comb begin
    result = '0;
    if (state_r == ST_FLUSH) begin
      result.hit      = found_r;
      result.slot     = SLOT_W'(placed_r ? pos_r : '0);
      result.count    = COUNT_W'(cf_r);
      result.ev_valid = evict_r;
      result.ev_page  = evict_r ? EVPAGE_W'(lastp_r) : '0;
    end
  end

endmodule

/* hw/rtl/lfu_aging_replacement_list.sv */
// Each accepted page takes one scan and one sweep of the entry memory at one slot per cycle,
// with a prepare step between them and the final write after; a zero page skips both passes.
// The result is registered. No new request is taken until the engine has finished the current
// one and returned to idle, and the result register is free.
// Reset empties every slot, clears the request tally and sets the aging period to 20;
// no clearing pass is needed, so a request can be accepted right after reset.
module lfu_aging_replacement_list #(
  parameter int SLOTS      = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [PAGE_BITS-1:0]              in_page,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [lfuar_pkg::SLOT_W-1:0]      out_slot,
  output logic [lfuar_pkg::COUNT_W-1:0]     out_count,
  output logic                              out_evicted_valid,
  output logic [lfuar_pkg::EVPAGE_W-1:0]    out_evicted_page,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfuar_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lfuar_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lfuar_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import lfuar_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic                eng_busy;
  logic                eng_done;
  result_t             eng_res;
  logic                start;
  logic                out_valid_r;
  result_t             out_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= AGING_PERIOD_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_AGING_PERIOD)) begin
      period_r <= pwdata[PERIOD_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_AGING_PERIOD) ? CFG_DATA_W'(period_r) : '0;

  // A new transaction enters only when the engine is idle and the result slot frees up.
  assign in_stall = eng_busy || (out_valid_r && out_stall);
  assign start    = in_valid && !in_stall;

  lfuar_engine #(
    .SLOTS      (SLOTS),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .page   (in_page),
    .period (period_r),
    .busy   (eng_busy),
    .done   (eng_done),
    .result (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_r <= eng_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_r.hit;
  assign out_slot          = out_r.slot;
  assign out_count         = out_r.count;
  assign out_evicted_valid = out_r.ev_valid;
  assign out_evicted_page  = out_r.ev_page;

endmodule

/* bench/lfuar_checker.sv */
// Checker for the LFU aging replacement list: predicts every lookup and compares each result.
module lfuar_checker
  import lfuar_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PAGE_BITS-1:0]  in_page,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_hit,
  input  logic [SLOT_W-1:0]     out_slot,
  input  logic [COUNT_W-1:0]    out_count,
  input  logic                  out_evicted_valid,
  input  logic [EVPAGE_W-1:0]   out_evicted_page,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending,
  output int                    requests,
  output int                    hits,
  output int                    evictions,
  output int                    zero_pages,
  output int                    saturated
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int                    REPORT_MAX = 50;

  // Predicted contents of the ordered list, highest count first.
  logic [PAGE_BITS-1:0]  slot_pg [SLOTS];
  logic [COUNT_BITS-1:0] slot_cnt[SLOTS];
  logic [7:0]            request_tally;
  logic [PERIOD_W-1:0]   aging_period;
  result_t               lookup_queue[$];
  int                    results_seen;

  task automatic report_mismatch(input string msg);
    if (fail_count < REPORT_MAX) $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Applies one page request to the predicted list and returns the expected result.
  task automatic lfu_access(input logic [PAGE_BITS-1:0] pg, output result_t r);
    int i, j, used, pos;
    bit was_hit, found;
    logic [PAGE_BITS-1:0]  mp;
    logic [COUNT_BITS-1:0] mc;
    r = '0;
    if (pg != '0) begin
      was_hit = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
        if (!was_hit && slot_pg[i] == pg) begin
          was_hit = 1'b1;
          if (slot_cnt[i] != COUNT_MAX) slot_cnt[i]++;
        end
      end
      if (!was_hit) begin
        used = 0;
        while (used < SLOTS && slot_pg[used] != '0) used++;
        if (used == SLOTS) begin
          r.ev_valid = 1'b1;
          r.ev_page  = EVPAGE_W'(slot_pg[SLOTS-1]);
          used       = SLOTS - 1;
        end
        for (i = used; i > 0; i--) begin
          slot_pg[i]  = slot_pg[i-1];
          slot_cnt[i] = slot_cnt[i-1];
        end
        slot_pg[0]  = pg;
        slot_cnt[0] = 1;
      end
      request_tally = request_tally + 8'd1;
      // A period of zero compares true every time, so it ages like a period of one.
      if (request_tally >= aging_period) begin
        request_tally = '0;
        for (i = 0; i < SLOTS; i++)
          if (slot_cnt[i] != '0) slot_cnt[i]--;
      end
      // Stable insertion sort by count, so equal counts keep their order.
      for (i = 1; i < SLOTS; i++) begin
        mp = slot_pg[i];
        mc = slot_cnt[i];
        j  = i;
        while (j > 0 && slot_cnt[j-1] < mc) begin
          slot_pg[j]  = slot_pg[j-1];
          slot_cnt[j] = slot_cnt[j-1];
          j--;
        end
        slot_pg[j]  = mp;
        slot_cnt[j] = mc;
      end
      found = 1'b0;
      pos   = 0;
      for (i = 0; i < SLOTS; i++) begin
        if (!found && slot_pg[i] == pg) begin
          found = 1'b1;
          pos   = i;
        end
      end
      r.hit   = was_hit;
      r.slot  = SLOT_W'(pos);
      r.count = COUNT_W'(slot_cnt[pos]);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_pg[i]  = '0;
        slot_cnt[i] = '0;
      end
      request_tally = '0;
      aging_period  = AGING_PERIOD_RESET;
      lookup_queue.delete();
      results_seen  = 0;
      fail_count    = 0;
      pending       = 0;
      requests      = 0;
      hits          = 0;
      evictions     = 0;
      zero_pages    = 0;
      saturated     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lookup_queue.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    results_seen));
        end else begin
          want = lookup_queue.pop_front();
          if (out_hit !== want.hit)
            report_mismatch($sformatf("result %0d: hit expected %0d, got %0d",
                                      results_seen, want.hit, out_hit));
          if (out_slot !== want.slot)
            report_mismatch($sformatf("result %0d: slot expected %0d, got %0d",
                                      results_seen, want.slot, out_slot));
          if (out_count !== want.count)
            report_mismatch($sformatf("result %0d: count expected %0d, got %0d",
                                      results_seen, want.count, out_count));
          if (out_evicted_valid !== want.ev_valid)
            report_mismatch($sformatf("result %0d: evicted_valid expected %0d, got %0d",
                                      results_seen, want.ev_valid, out_evicted_valid));
          if (out_evicted_page !== want.ev_page)
            report_mismatch($sformatf("result %0d: evicted_page expected %0h, got %0h",
                                      results_seen, want.ev_page, out_evicted_page));
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        lfu_access(in_page, want);
        lookup_queue.push_back(want);
        requests++;
        if (in_page == '0) zero_pages++;
        if (want.hit) hits++;
        if (want.ev_valid) evictions++;
        if (want.hit && want.count == COUNT_W'(COUNT_MAX)) saturated++;
      end
      if (psel && penable && pwrite && pready && paddr == REG_AGING_PERIOD)
        aging_period = pwdata[PERIOD_W-1:0];
      pending = lookup_queue.size();
    end
  end

endmodule

/* bench/tb.sv */
// Testbench top for the LFU aging replacement list: stimulus, stalls, watchdog and verdict.
module tb;
  import lfuar_pkg::*;

  localparam int SLOTS          = 16;
  localparam int PAGE_BITS      = 16;
  localparam int COUNT_BITS     = 8;
  localparam int LATENCY        = 2*SLOTS + 2;
  localparam int RESET_CYCLES   = 9;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 130;
  localparam int HOT_BURST      = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PAGE_BITS-1:0]  in_page;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_hit;
  logic [SLOT_W-1:0]     out_slot;
  logic [COUNT_W-1:0]    out_count;
  logic                  out_evicted_valid;
  logic [EVPAGE_W-1:0]   out_evicted_page;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count, pending, requests, hits, evictions, zero_pages, saturated;
  int idle_cycles;

  bit                   sender_eager;
  logic [PAGE_BITS-1:0] page_pool[32];
  int                   pool_size;

  lfu_aging_replacement_list #(
    .SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_page(in_page),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_slot(out_slot), .out_count(out_count),
    .out_evicted_valid(out_evicted_valid), .out_evicted_page(out_evicted_page),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lfuar_checker #(
    .SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)
  ) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_page(in_page),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_slot(out_slot), .out_count(out_count),
    .out_evicted_valid(out_evicted_valid), .out_evicted_page(out_evicted_page),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .requests(requests), .hits(hits),
    .evictions(evictions), .zero_pages(zero_pages), .saturated(saturated)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Ends the run when nothing has moved on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int sender_gap();
    int r;
    if (sender_eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // Mostly pages from the working set, skewed toward its low indexes so that some pages
  // are hot; a few fresh random pages and a few zero pages.
  function automatic logic [PAGE_BITS-1:0] pick_page();
    int r, a, b;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return PAGE_BITS'($urandom_range(1, 2**PAGE_BITS - 1));
    a = $urandom_range(0, pool_size - 1);
    b = $urandom_range(0, pool_size - 1);
    return page_pool[(a < b) ? a : b];
  endfunction

  task automatic new_working_set();
    case ($urandom_range(0, 2))
      0:       pool_size = $urandom_range(2, 8);
      1:       pool_size = $urandom_range(12, 16);
      default: pool_size = $urandom_range(17, 32);
    endcase
    for (int i = 0; i < pool_size; i++)
      page_pool[i] = PAGE_BITS'($urandom_range(1, 2**PAGE_BITS - 1));
  endtask

  task automatic send_page(input logic [PAGE_BITS-1:0] pg);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_page  <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering requests until every outstanding lookup has produced its result.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_aging_period(input logic [PERIOD_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_AGING_PERIOD;
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stalls with calm stretches, plus a long hold-off now and then
  // so that the block backs up and stalls its input.
  initial begin : receiver
    int taken, next_hold, stall_left, mode_left, r;
    bit calm;
    taken      = 0;
    next_hold  = 150;
    stall_left = 0;
    mode_left  = 0;
    calm       = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      @(negedge clk);
      if (taken >= next_hold) begin
        next_hold += 650;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          calm      = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 400);
        end else begin
          mode_left--;
        end
        if (stall_left == 0 && !calm) begin
          r = $urandom_range(0, 99);
          if (r < 10) stall_left = $urandom_range(1, 3);
          else if (r < 12) stall_left = $urandom_range(15, 60);
        end
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    logic [PERIOD_W-1:0] period;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_page      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sender_eager = 1'b0;
    pool_size    = 1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme pages, a zero page on a partly filled and on a full list, hits,
    // filling all slots and evicting the least used entries.
    send_page(16'h0001);
    send_page(16'hFFFF);
    send_page(16'h8000);
    send_page(16'h0000);
    send_page(16'h0001);
    send_page(16'hFFFF);
    for (int i = 0; i < 15; i++) send_page(PAGE_BITS'(16'h5A00 + i));
    send_page(16'h0000);
    send_page(16'h5A0E);
    send_page(16'hAAAA);
    send_page(16'h5555);
    wait_all_results();

    // Random phases, each with its own aging period and working set. Going from 255
    // to 5 usually lowers the period below the running tally.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       period = 8'd255;
        1:       period = 8'd5;
        2:       period = 8'd0;
        3:       period = 8'd1;
        4:       period = 8'd2;
        5:       period = 8'd255;
        default: period = $urandom_range(0, 1) ? PERIOD_W'($urandom_range(1, 255))
                                               : PERIOD_W'($urandom_range(1, 12));
      endcase
      write_aging_period(period);
      new_working_set();
      sender_eager = ($urandom_range(0, 3) == 0);
      // One page hammered long enough to saturate its count under slow aging.
      if (ph == 0) repeat (HOT_BURST) send_page(page_pool[0]);
      repeat (PHASE_ITEMS) send_page(pick_page());
      wait_all_results();
    end

    $display("Covered %0d requests: %0d hits, %0d evictions, %0d zero pages, %0d saturated hits",
             requests, hits, evictions, zero_pages, saturated);
    $display("Aging periods 20, 255, 5, 0, 1, 2 and random ones; %0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lfuar_pkg.sv
hw/rtl/lfuar_engine.sv
hw/rtl/lfu_aging_replacement_list.sv
bench/lfuar_checker.sv
bench/tb.sv
